// ===== design/mtep_pkg.sv =====
// Shared types and constants of the MIDI track event parser.
// No dependencies; every other design file imports this package.
package mtep_pkg;

    // Byte codes that the parser recognizes.
    localparam logic [7:0] META_STATUS = 8'hFF;
    localparam logic [7:0] META_TEXT   = 8'h03;
    localparam logic [7:0] META_EOT    = 8'h2F;

    // Reset value of the delta time enable register.
    localparam logic TIMESTAMP_PRESENT_RESET = 1'b1;

    // One input item: a raw track byte.
    typedef struct packed {
        logic [7:0] data_byte;
    } t_in_item;

    // One result item: a completed event.
    typedef struct packed {
        logic [31:0] delta_time;
        logic [7:0]  status_byte;
        logic [7:0]  key_byte;
        logic [7:0]  value_byte;
        logic        end_of_track;
        logic        bad_status;
        logic        unknown_meta;
    } t_out_item;

endpackage

// ===== design/mtep_stream_if.sv =====
// Valid/ready stream channel used for the byte input and the event output.
// Depends on mtep_pkg for the default payload type.
interface mtep_stream_if
    import mtep_pkg::*;
#(
    parameter type t_payload = t_in_item
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== design/mtep_in_stage.sv =====
// Input register of the parser: holds one accepted track byte.
// Depends on mtep_pkg and mtep_stream_if.
module mtep_in_stage
    import mtep_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    mtep_stream_if.sink   i_in,
    input  logic          i_take,
    output logic          o_valid,
    output logic [7:0]    o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // The register accepts a new byte when it is empty or drains this cycle.
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.payload.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== design/mtep_parser.sv =====
// Event parsing state machine: consumes one byte per step and builds events.
// Depends on mtep_pkg for byte codes and the result type.
module mtep_parser
    import mtep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_timestamp_present,
    output logic        o_res_valid,
    output t_out_item   o_res
);

    localparam logic [2:0] PH_END  = 3'd0;
    localparam logic [2:0] PH_TIME = 3'd1;
    localparam logic [2:0] PH_STAT = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_VAL  = 3'd4;
    localparam logic [2:0] PH_TEXT = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_acc, n_acc;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_key, n_key;
    logic [7:0]  r_value, n_value;
    logic [7:0]  r_text, n_text;
    logic        r_track_ended, n_track_ended;
    logic        r_status_err, n_status_err;

    logic [2:0]  ph;
    logic [31:0] acc;
    logic [31:0] acc_sum;
    logic        emit;
    logic        eot;
    logic        unknown;

    // Next state and result for the byte taken in this step.
    always_comb begin
        n_phase       = r_phase;
        n_acc         = r_acc;
        n_status      = r_status;
        n_key         = r_key;
        n_value       = r_value;
        n_text        = r_text;
        n_track_ended = r_track_ended;
        n_status_err  = r_status_err;
        ph            = r_phase;
        acc           = r_acc;
        emit          = 1'b0;
        eot           = 1'b0;
        unknown       = 1'b0;
        acc_sum       = r_acc + {25'd0, i_byte[6:0]};

        if (i_step && !r_track_ended) begin
            // A new event starts with a cleared accumulator.
            if (r_phase == PH_END) begin
                acc     = '0;
                ph      = i_timestamp_present ? PH_TIME : PH_STAT;
                acc_sum = {25'd0, i_byte[6:0]};
            end
            n_phase = ph;
            n_acc   = acc;

            case (ph)
                PH_TIME: begin
                    // Seven bits per byte, a set high bit means more follow.
                    if (i_byte[7]) begin
                        n_acc = {acc_sum[24:0], 7'd0};
                    end else begin
                        n_acc   = acc_sum;
                        n_phase = PH_STAT;
                    end
                end
                PH_STAT: begin
                    n_status     = i_byte;
                    n_status_err = !i_byte[7];
                    n_phase      = PH_KEY;
                end
                PH_KEY: begin
                    n_key   = i_byte;
                    n_phase = PH_VAL;
                end
                PH_VAL: begin
                    n_value = i_byte;
                    if (r_status != META_STATUS) begin
                        emit = 1'b1;
                    end else if (r_key == META_TEXT) begin
                        // A text meta event skips its value-byte length.
                        if (i_byte != 8'd0) begin
                            n_text  = i_byte - 8'd1;
                            n_phase = PH_TEXT;
                        end else begin
                            emit = 1'b1;
                        end
                    end else if (r_key == META_EOT) begin
                        n_track_ended = 1'b1;
                        eot           = 1'b1;
                        emit          = 1'b1;
                    end else begin
                        unknown = 1'b1;
                        emit    = 1'b1;
                    end
                end
                PH_TEXT: begin
                    if (r_text != 8'd0) begin
                        n_text = r_text - 8'd1;
                    end else begin
                        emit = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_END;
                end
            endcase

            if (emit) begin
                n_phase = PH_END;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_END;
            r_track_ended <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_track_ended <= n_track_ended;
        end
    end

    // Event fields held across bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_status     <= '0;
            r_key        <= '0;
            r_value      <= '0;
            r_text       <= '0;
            r_status_err <= 1'b0;
        end else begin
            r_acc        <= n_acc;
            r_status     <= n_status;
            r_key        <= n_key;
            r_value      <= n_value;
            r_text       <= n_text;
            r_status_err <= n_status_err;
        end
    end

    assign o_res_valid        = emit;
    assign o_res.delta_time   = n_acc;
    assign o_res.status_byte  = n_status;
    assign o_res.key_byte     = n_key;
    assign o_res.value_byte   = n_value;
    assign o_res.end_of_track = eot;
    assign o_res.bad_status   = n_status_err;
    assign o_res.unknown_meta = unknown;

endmodule

// ===== design/mtep_out_stage.sv =====
// Result register of the parser: holds one event until the sink takes it.
// Depends on mtep_pkg and mtep_stream_if.
module mtep_out_stage
    import mtep_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_out_item     i_item,
    output logic          o_free,
    mtep_stream_if.source o_out
);

    logic      r_valid;
    t_out_item r_item;

    // Free when empty or when the held event transfers this cycle.
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_item <= i_item;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.payload = r_item;

endmodule

// ===== design/midi_track_event_parser_top.sv =====
// MIDI track event parser: takes one track byte per clock and returns one
// event record per completed event. A byte is accepted in every cycle while
// the result register can take an event. When a finished event waits there
// for the sink, parsing pauses, and the input stalls once the input register
// also holds a byte. Each byte is registered in the input register and
// then parsed against the event state. A finished event is formed when its
// last byte is parsed and is registered in the result register, from which
// it can transfer out. Bytes that end no event produce nothing, and after
// the end-of-track event all bytes are taken and dropped until reset. The
// delta time enable register is sampled when a new event begins and should
// be written only while the block is idle.
// Depends on mtep_pkg, mtep_stream_if, mtep_in_stage, mtep_parser and
// mtep_out_stage.
module midi_track_event_parser_top
    import mtep_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    mtep_stream_if.sink   i_in,
    mtep_stream_if.source o_out
);

    logic      r_timestamp_present;
    logic      byte_valid;
    logic [7:0] byte_data;
    logic      out_free;
    logic      step;
    logic      res_valid;
    t_out_item res;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timestamp_present <= TIMESTAMP_PRESENT_RESET;
        end else if (i_cfg_we) begin
            r_timestamp_present <= i_cfg_wdata;
        end
    end

    // A held byte is parsed whenever the result register can take an event.
    assign step = byte_valid && out_free;

    mtep_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (step),
        .o_valid (byte_valid),
        .o_byte  (byte_data)
    );

    mtep_parser u_parser (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (step),
        .i_byte              (byte_data),
        .i_timestamp_present (r_timestamp_present),
        .o_res_valid         (res_valid),
        .o_res               (res)
    );

    mtep_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_item  (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule
